/* src/ucfc_pkg.sv */
package ucfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_FAIL  = 2'd1,
        STATUS_TOO_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] computed_crc;
    } t_result;

    // CRC-8, poly 0x07, MSB first; unrolls into a small XOR network
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/ucfc_frame_core.sv */
module ucfc_frame_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ucfc_pkg::BYTE_W-1:0] i_cfg_escape_byte,
    input  logic                  i_accept,
    input  logic [ucfc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                  i_frame_end,
    output logic                  o_push,
    output ucfc_pkg::t_result     o_result
);
    import ucfc_pkg::*;

    logic [BYTE_W-1:0] r_escape, n_escape;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_held_vld, n_held_vld;
    logic              r_esc_pend, n_esc_pend;
    logic [BYTE_W-1:0] w_crc_upd;

    assign w_crc_upd = crc8_update(r_crc, r_held);

    always_comb begin
        n_escape   = i_cfg_we ? i_cfg_escape_byte : r_escape;
        n_crc      = r_crc;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_esc_pend = r_esc_pend;
        o_push     = 1'b0;
        o_result.status       = STATUS_TOO_SHORT;
        o_result.computed_crc = '0;
        if (i_accept) begin
            if (!i_frame_end) begin
                // the held word is body, not CRC: unstuff and fold it now
                if (r_held_vld) begin
                    if (r_esc_pend) begin
                        n_crc      = w_crc_upd;
                        n_esc_pend = 1'b0;
                    end else if (r_held == r_escape) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        n_crc = w_crc_upd;
                    end
                end
                n_held     = i_data_byte;
                n_held_vld = 1'b1;
            end else begin
                o_push = 1'b1;
                if (r_held_vld) begin
                    o_result.status       = (r_held != r_crc) ? STATUS_CRC_FAIL : STATUS_OK;
                    o_result.computed_crc = r_crc;
                end
                n_crc      = CRC_INIT;
                n_held     = '0;
                n_held_vld = 1'b0;
                n_esc_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape   <= '0;
            r_crc      <= CRC_INIT;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_esc_pend <= 1'b0;
        end else begin
            r_escape   <= n_escape;
            r_crc      <= n_crc;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_esc_pend <= n_esc_pend;
        end
    end

endmodule

/* src/ucfc_out_buf.sv */
module ucfc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ucfc_pkg::t_result i_push_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output ucfc_pkg::t_result o_out_data,
    output logic              o_full
);
    import ucfc_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       w_pop;

    assign w_pop       = (r_cnt != 2'd0) && !i_out_stall;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot0;
    assign o_full      = (r_cnt == 2'd2);

    // two words: head register plus one skid slot
    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        case ({i_push, w_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_slot0 = i_push_data;
                end else begin
                    n_slot1 = i_push_data;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_cnt   = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_slot0 = i_push_data;
                end else begin
                    n_slot0 = r_slot1;
                    n_slot1 = i_push_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

/* src/unescape_crc8_frame_check_unit.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------
// cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_escape_byte
// in       | i_in_valid  / o_in_stall   | i_data_byte, i_frame_end
// out      | o_out_valid / i_out_stall  | o_status, o_computed_crc
//
// One byte per cycle unless stalled; the unstuff and CRC fold of the held
// byte is one XOR network between the frame state registers. A result
// appears in the cycle after its end-marker word when the output buffer is
// empty. Synchronous active-low reset clears frame state, the escape
// register and the output buffer. The output buffer holds two words; input
// stalls while both are taken, which needs the output to have stalled.
module unescape_crc8_frame_check_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ucfc_pkg::BYTE_W-1:0] i_cfg_escape_byte,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ucfc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_frame_end,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ucfc_pkg::STATUS_W-1:0] o_status,
    output logic [ucfc_pkg::BYTE_W-1:0] o_computed_crc
);
    import ucfc_pkg::*;

    logic    w_accept;
    logic    w_push;
    logic    w_full;
    t_result w_result;
    t_result w_out_data;

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = w_full;
    assign w_accept       = i_in_valid && !w_full;
    assign o_status       = w_out_data.status;
    assign o_computed_crc = w_out_data.computed_crc;

    ucfc_frame_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_escape_byte (i_cfg_escape_byte),
        .i_accept          (w_accept),
        .i_data_byte       (i_data_byte),
        .i_frame_end       (i_frame_end),
        .o_push            (w_push),
        .o_result          (w_result)
    );

    ucfc_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (w_out_data),
        .o_full      (w_full)
    );

`ifndef NO_ASSERTIONS
    a_stall_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output buffer");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_end) |=> o_out_valid)
        else $error("end marker accepted but no result word");

    a_short_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_TOO_SHORT) |-> (o_computed_crc == '0))
        else $error("too-short frame reports nonzero crc");

    a_ok_only_nonfull_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("result pushed into full output buffer");
`endif

endmodule

/* tb/unescape_crc8_frame_check_unit_tb.sv */
`timescale 1ns / 100ps

module unescape_crc8_frame_check_unit_tb;
    import ucfc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 100;
    localparam int SETTLE_CYCLES = 4;

    // predicts the frame verdicts and checks them in arrival order
    class frame_verdict_board;
        logic [BYTE_W-1:0] escape_val;
        logic [BYTE_W-1:0] crc_run;
        logic [BYTE_W-1:0] held;
        bit                held_ok;
        bit                esc_open;
        t_result           verdict_q[$];
        int                errors;

        function new();
            escape_val = CRC_INIT;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc_run = CRC_INIT;
            held = '0;
            held_ok = 1'b0;
            esc_open = 1'b0;
        endfunction

        function void set_escape(input logic [BYTE_W-1:0] v);
            escape_val = v;
        endfunction

        function logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] c,
                                             input logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] r;
            r = c ^ b;
            repeat (BYTE_W) r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            return r;
        endfunction

        // unstuff one body byte, then fold it
        function void fold_body(input logic [BYTE_W-1:0] b);
            if (esc_open) begin
                crc_run = crc_byte(crc_run, b);
                esc_open = 1'b0;
            end else if (b == escape_val) begin
                esc_open = 1'b1;
            end else begin
                crc_run = crc_byte(crc_run, b);
            end
        endfunction

        function void absorb_word(input logic [BYTE_W-1:0] b, input logic last);
            t_result v;
            if (!last) begin
                if (held_ok) fold_body(held);
                held = b;
                held_ok = 1'b1;
            end else begin
                if (!held_ok) begin
                    v.status = STATUS_TOO_SHORT;
                    v.computed_crc = '0;
                end else begin
                    v.status = (held != crc_run) ? STATUS_CRC_FAIL : STATUS_OK;
                    v.computed_crc = crc_run;
                end
                verdict_q = {verdict_q, v};
                clear_frame();
            end
        endfunction

        task report(input string what);
            $display("%0t ns: MISMATCH %s", $time, what);
            errors++;
        endtask

        task check_verdict(input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] crc);
            t_result v;
            if (verdict_q.size() == 0) begin
                report($sformatf("unexpected word status=%0d crc=%02h", st, crc));
            end else begin
                v = verdict_q.pop_front();
                if (st !== v.status)
                    report($sformatf("status got %0d want %0d", st, v.status));
                if (crc !== v.computed_crc)
                    report($sformatf("crc got %02h want %02h", crc, v.computed_crc));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [BYTE_W-1:0]   i_cfg_escape_byte;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                i_frame_end;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_computed_crc;

    frame_verdict_board board;
    logic [BYTE_W-1:0]  raw_q[$];
    logic [BYTE_W-1:0]  frame_q[$];
    logic [BYTE_W-1:0]  cur_escape;
    bit                 sender_idles;
    bit                 receiver_idles;
    bit                 hold_req;
    int                 words_in;
    int                 quiet_cycles = 0;

    unescape_crc8_frame_check_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_escape_byte (i_cfg_escape_byte),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_frame_end       (i_frame_end),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_computed_crc    (o_computed_crc)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        int stall_left;
        int hold_left;
        i_out_stall = 1'b0;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 15);
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_verdict(o_status, o_computed_crc);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one frame word; valid stays high afterwards until the next gap or drain
    task automatic put_word(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (sender_idles && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_data_byte = 8'($urandom);
            i_frame_end = 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_data_byte = b;
        i_frame_end = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.absorb_word(b, last);
        words_in++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) put_word(frame_q[i], 1'b0);
        put_word(8'($urandom), 1'b1);
    endtask

    // stuff raw_q with the current escape and append its CRC, or a corrupted one
    task automatic build_frame(input bit tail_esc, input bit bad_crc, input int lone_pct);
        logic [BYTE_W-1:0] c;
        c = CRC_INIT;
        frame_q.delete();
        foreach (raw_q[i]) begin
            c = board.crc_byte(c, raw_q[i]);
            if (raw_q[i] == cur_escape) begin
                frame_q = {frame_q, cur_escape};
                frame_q = {frame_q, cur_escape};
            end else begin
                if ($urandom_range(1, 100) <= lone_pct) frame_q = {frame_q, cur_escape};
                frame_q = {frame_q, raw_q[i]};
            end
        end
        if (tail_esc) frame_q = {frame_q, cur_escape};
        frame_q = {frame_q, bad_crc ? c ^ (8'd1 << $urandom_range(0, 7)) : c};
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_escape(input logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_escape_byte = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_escape(v);
        cur_escape = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
            raw_q.delete();
            repeat (len)
                raw_q = {raw_q, ($urandom_range(0, 3) == 0) ? cur_escape : 8'($urandom)};
            build_frame($urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0, 30);
        end else if (kind < 80) begin
            frame_q.delete();
        end else begin
            len = $urandom_range(1, 8);
            frame_q.delete();
            repeat (len)
                frame_q = {frame_q, ($urandom_range(0, 2) == 0) ? cur_escape : 8'($urandom)};
        end
        send_frame();
    endtask

    initial begin
        int phase_end;
        board = new();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_escape_byte = '0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_frame_end = 1'b0;
        cur_escape = '0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        hold_req = 1'b0;
        words_in = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // escape is still at its reset value of zero here
        put_word(8'hFF, 1'b1);
        put_word(8'h00, 1'b0);
        put_word(8'hA5, 1'b1);
        put_word(8'hFF, 1'b0);
        put_word(8'h00, 1'b1);
        drain();

        // doubled escape, lone escape before data, escape just before the CRC
        write_escape(8'h7D);
        raw_q = '{8'h7D, 8'hAA};
        build_frame(1'b1, 1'b0, 100);
        send_frame();
        drain();

        write_escape(8'hFF);
        raw_q = '{8'hFF, 8'h00};
        build_frame(1'b0, 1'b1, 0);
        send_frame();

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: write_escape(8'($urandom));
                1: write_escape(8'h00);
                2: write_escape(8'hFF);
                default: write_escape(8'($urandom));
            endcase
            sender_idles = (ph != 3);
            receiver_idles = (ph != 3);
            if (ph == 1) hold_req = 1'b1;
            phase_end = words_in + PHASE_WORDS;
            while (words_in < phase_end) random_frame();
        end
        drain();

        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
src/ucfc_pkg.sv
src/ucfc_frame_core.sv
src/ucfc_out_buf.sv
src/unescape_crc8_frame_check_unit.sv
tb/unescape_crc8_frame_check_unit_tb.sv
